// ===== rtl/core/mdm_pkg.sv =====
// Package for the data memory block: widths, operation codes, record kinds,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package mdm_pkg;

  localparam int OP_W   = 3;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int CELL_W = 12;
  localparam int KIND_W = 2;

  localparam int MEM_DEPTH_DEF    = 2304;
  localparam int SRAM_BASE_DEF    = 256;
  localparam int SP_LOW_ADDR_DEF  = 93;
  localparam int SP_HIGH_ADDR_DEF = 94;

  localparam logic [OP_W-1:0] OP_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_TAKE  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SRC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEST = 2'd2;

  localparam logic [DATA_W-1:0] BYTE_FF = 8'hFF;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_RD_WAIT,
    S_SPH,
    S_SPCAP,
    S_STACK,
    S_POP_RD,
    S_PTR_L,
    S_PTR_H,
    S_WALK,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MA_ITEM,
    MA_SPL,
    MA_SPH,
    MA_SP,
    MA_WALK
  } mem_sel_t;

  typedef enum logic [1:0] {
    WD_VAL,
    WD_ZERO,
    WD_SPLO,
    WD_SPHI
  } wd_sel_t;

  typedef enum logic [1:0] {
    HS_ZERO,
    HS_FF,
    HS_RDATA,
    HS_RECORD
  } hold_sel_t;

  typedef enum logic [2:0] {
    NT_KEEP,
    NT_SRC_ADDR,
    NT_DST_ADDR,
    NT_SRC_SP,
    NT_DST_SP,
    NT_CLEAR
  } note_sel_t;

  typedef struct packed {
    logic      load_item;
    mem_sel_t  mem_sel;
    logic      mem_we;
    wd_sel_t   wd_sel;
    logic      cap_splo;
    logic      cap_sp;
    logic      sp_inc;
    logic      sp_dec;
    note_sel_t note_sel;
    logic      hold_en;
    hold_sel_t hold_sel;
    logic      res_load;
    logic      walk_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            addr_ok;
    logic            push_ok;
    logic            pop_ok;
    logic            walk_done;
    logic            out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mdm_ifs.sv =====
// Valid/ready channel interfaces for operation items and result items.
// Depends on mdm_pkg.
`default_nettype none
interface mdm_in_if;
  import mdm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   write_value;
  modport source (output valid, output operation, output address, output write_value,
                  input ready);
  modport sink (input valid, input operation, input address, input write_value,
                output ready);
endinterface

interface mdm_out_if;
  import mdm_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_data;
  logic [CELL_W-1:0]   record_cell;
  logic [KIND_W-1:0]   record_kind;
  modport source (output valid, output read_data, output record_cell, output record_kind,
                  input ready);
  modport sink (input valid, input read_data, input record_cell, input record_kind,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mdm_ctrl.sv =====
// Controller state machine: sequences memory accesses for each operation.
// Depends on mdm_pkg; drives mdm_datapath through dp_cmd_t.
`default_nettype none
module mdm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mdm_pkg::dp_status_t status,
  output mdm_pkg::dp_cmd_t    cmd
);
  import mdm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.mem_sel  = MA_WALK;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_ZERO;
        cmd.walk_inc = 1'b1;
        if (status.walk_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.hold_en  = 1'b1;
        cmd.hold_sel = HS_ZERO;
        state_next   = S_OUT;
        unique case (status.op) inside
          OP_READ: begin
            if (status.addr_ok) begin
              cmd.mem_sel  = MA_ITEM;
              cmd.note_sel = NT_SRC_ADDR;
              state_next   = S_RD_WAIT;
            end else begin
              cmd.hold_sel = HS_FF;
            end
          end
          OP_WRITE: begin
            if (status.addr_ok) begin
              cmd.mem_sel  = MA_ITEM;
              cmd.mem_we   = 1'b1;
              cmd.wd_sel   = WD_VAL;
              cmd.note_sel = NT_DST_ADDR;
            end
          end
          OP_PUSH, OP_POP: begin
            cmd.mem_sel = MA_SPL;
            state_next  = S_SPH;
          end
          OP_TAKE: begin
            cmd.hold_sel = HS_RECORD;
            cmd.note_sel = NT_CLEAR;
          end
          OP_CLEAR: begin
            cmd.note_sel = NT_CLEAR;
            state_next   = S_WALK;
          end
          default: begin
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.hold_en  = 1'b1;
        cmd.hold_sel = HS_RDATA;
        state_next   = S_OUT;
      end
      S_SPH: begin
        cmd.mem_sel  = MA_SPH;
        cmd.cap_splo = 1'b1;
        state_next   = S_SPCAP;
      end
      S_SPCAP: begin
        cmd.cap_sp = 1'b1;
        state_next = S_STACK;
      end
      S_STACK: begin
        state_next = S_OUT;
        if (status.op == OP_PUSH) begin
          if (status.push_ok) begin
            cmd.mem_sel  = MA_SP;
            cmd.mem_we   = 1'b1;
            cmd.wd_sel   = WD_VAL;
            cmd.note_sel = NT_DST_SP;
            cmd.sp_dec   = 1'b1;
            state_next   = S_PTR_L;
          end
        end else begin
          if (status.pop_ok) begin
            cmd.sp_inc = 1'b1;
            state_next = S_POP_RD;
          end else begin
            cmd.hold_en  = 1'b1;
            cmd.hold_sel = HS_FF;
          end
        end
      end
      S_POP_RD: begin
        cmd.mem_sel  = MA_SP;
        cmd.note_sel = NT_SRC_SP;
        state_next   = S_PTR_L;
      end
      S_PTR_L: begin
        cmd.mem_sel  = MA_SPL;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_SPLO;
        cmd.hold_en  = 1'b1;
        cmd.hold_sel = (status.op == OP_POP) ? HS_RDATA : HS_ZERO;
        state_next   = S_PTR_H;
      end
      S_PTR_H: begin
        cmd.mem_sel = MA_SPH;
        cmd.mem_we  = 1'b1;
        cmd.wd_sel  = WD_SPHI;
        state_next  = S_OUT;
      end
      S_WALK: begin
        cmd.mem_sel  = MA_WALK;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_ZERO;
        cmd.walk_inc = 1'b1;
        if (status.walk_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdm_datapath.sv =====
// Datapath: data store with one registered port, stack pointer, access record,
// pending result and output register. Depends on mdm_pkg; driven by mdm_ctrl.
`default_nettype none
module mdm_datapath #(
  parameter int MEM_DEPTH    = mdm_pkg::MEM_DEPTH_DEF,
  parameter int SRAM_BASE    = mdm_pkg::SRAM_BASE_DEF,
  parameter int SP_LOW_ADDR  = mdm_pkg::SP_LOW_ADDR_DEF,
  parameter int SP_HIGH_ADDR = mdm_pkg::SP_HIGH_ADDR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mdm_pkg::dp_cmd_t            cmd,
  output mdm_pkg::dp_status_t         status,
  input  logic [mdm_pkg::OP_W-1:0]    operation,
  input  logic [mdm_pkg::ADDR_W-1:0]  address,
  input  logic [mdm_pkg::DATA_W-1:0]  write_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mdm_pkg::DATA_W-1:0]  read_data,
  output logic [mdm_pkg::CELL_W-1:0]  record_cell,
  output logic [mdm_pkg::KIND_W-1:0]  record_kind
);
  import mdm_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [ADDR_W-1:0] BASE_A  = ADDR_W'(SRAM_BASE);
  localparam logic [AW-1:0]     WALK_END = AW'(MEM_DEPTH - 1);

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     mem_idx;
  logic [DATA_W-1:0] wdata;

  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] sp_lo;
  logic [ADDR_W-1:0] sp;
  logic [AW-1:0]     walk;
  logic [CELL_W-1:0] last_cell;
  logic [KIND_W-1:0] last_kind;
  logic [DATA_W-1:0] hold_data;
  logic [CELL_W-1:0] hold_cell;
  logic [KIND_W-1:0] hold_kind;

  always_comb begin
    case (cmd.mem_sel)
      MA_ITEM: mem_idx = addr[AW-1:0];
      MA_SPL:  mem_idx = AW'(SP_LOW_ADDR);
      MA_SPH:  mem_idx = AW'(SP_HIGH_ADDR);
      MA_SP:   mem_idx = sp[AW-1:0];
      MA_WALK: mem_idx = walk;
      default: mem_idx = walk;
    endcase
    case (cmd.wd_sel)
      WD_VAL:  wdata = val;
      WD_ZERO: wdata = '0;
      WD_SPLO: wdata = sp[7:0];
      WD_SPHI: wdata = sp[15:8];
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_idx] <= wdata;
    end
    rdata <= mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op   <= operation;
      addr <= address;
      val  <= write_value;
    end
    if (cmd.cap_splo) begin
      sp_lo <= rdata;
    end
    if (cmd.cap_sp) begin
      sp <= {rdata, sp_lo};
    end else if (cmd.sp_inc) begin
      sp <= sp + 1'b1;
    end else if (cmd.sp_dec) begin
      sp <= sp - 1'b1;
    end
    if (cmd.hold_en) begin
      case (cmd.hold_sel)
        HS_ZERO: begin
          hold_data <= '0;
          hold_cell <= '0;
          hold_kind <= KIND_NONE;
        end
        HS_FF: begin
          hold_data <= BYTE_FF;
          hold_cell <= '0;
          hold_kind <= KIND_NONE;
        end
        HS_RDATA: begin
          hold_data <= rdata;
          hold_cell <= '0;
          hold_kind <= KIND_NONE;
        end
        HS_RECORD: begin
          hold_data <= '0;
          hold_cell <= last_cell;
          hold_kind <= last_kind;
        end
        default: begin
          hold_data <= '0;
          hold_cell <= '0;
          hold_kind <= KIND_NONE;
        end
      endcase
    end
    if (cmd.res_load) begin
      read_data   <= hold_data;
      record_cell <= hold_cell;
      record_kind <= hold_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk      <= '0;
      last_cell <= '0;
      last_kind <= KIND_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.walk_inc) begin
        walk <= (walk == WALK_END) ? '0 : walk + 1'b1;
      end
      case (cmd.note_sel)
        NT_SRC_ADDR: begin
          last_cell <= addr[CELL_W-1:0];
          last_kind <= KIND_SRC;
        end
        NT_DST_ADDR: begin
          last_cell <= addr[CELL_W-1:0];
          last_kind <= KIND_DEST;
        end
        NT_SRC_SP: begin
          last_cell <= sp[CELL_W-1:0];
          last_kind <= KIND_SRC;
        end
        NT_DST_SP: begin
          last_cell <= sp[CELL_W-1:0];
          last_kind <= KIND_DEST;
        end
        NT_CLEAR: begin
          last_cell <= '0;
          last_kind <= KIND_NONE;
        end
        default: begin
        end
      endcase
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.op        = op;
    status.addr_ok   = (addr < DEPTH_A);
    status.push_ok   = (sp > BASE_A) && (sp <= LAST_A);
    status.pop_ok    = (sp < LAST_A);
    status.walk_done = (walk == WALK_END);
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcu_data_memory_with_stack.sv =====
// Top level of the data memory with stack pointer: controller plus datapath.
// Depends on mdm_pkg, mdm_ifs, mdm_ctrl and mdm_datapath.
//
//   channel  dir  payload
//   in_ch    in   operation[2:0], address[15:0], write_value[7:0]
//   out_ch   out  read_data[7:0], record_cell[11:0], record_kind[1:0]
//
// One operation at a time through a single memory port with registered read.
// Clear walks the store one cell a cycle.
// After reset a clearing pass over the whole store runs before the first transfer.
// A result waiting in the output register holds the block only at its last step.
`default_nettype none
module mcu_data_memory_with_stack #(
  parameter int MEM_DEPTH    = mdm_pkg::MEM_DEPTH_DEF,
  parameter int SRAM_BASE    = mdm_pkg::SRAM_BASE_DEF,
  parameter int SP_LOW_ADDR  = mdm_pkg::SP_LOW_ADDR_DEF,
  parameter int SP_HIGH_ADDR = mdm_pkg::SP_HIGH_ADDR_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mdm_in_if.sink     in_ch,
  mdm_out_if.source  out_ch
);
  import mdm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  mdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mdm_datapath #(
    .MEM_DEPTH    (MEM_DEPTH),
    .SRAM_BASE    (SRAM_BASE),
    .SP_LOW_ADDR  (SP_LOW_ADDR),
    .SP_HIGH_ADDR (SP_HIGH_ADDR)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (in_ch.operation),
    .address     (in_ch.address),
    .write_value (in_ch.write_value),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .read_data   (out_ch.read_data),
    .record_cell (out_ch.record_cell),
    .record_kind (out_ch.record_kind)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mcu_data_memory_with_stack: random and directed
// operations over the in/out valid-ready channels, checked against a local data space model.
// Depends on mdm_pkg, mdm_ifs and the RTL of the block.
module tb_top;
  import mdm_pkg::*;

  localparam int DEPTH       = MEM_DEPTH_DEF;
  localparam int LAST_CELL   = MEM_DEPTH_DEF - 1;
  localparam int SP_LO       = SP_LOW_ADDR_DEF;
  localparam int SP_HI       = SP_HIGH_ADDR_DEF;
  localparam int STACK_FLOOR = SRAM_BASE_DEF;
  localparam int QUIET_LIMIT = 12000;
  localparam int WORK_ITEMS  = 925;

  typedef struct {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;
    bit                drain;
  } op_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CELL_W-1:0] record_cell;
    logic [KIND_W-1:0] record_kind;
  } reply_t;

  logic clk;
  logic rst;

  mdm_in_if  in_ch();
  mdm_out_if out_ch();

  mcu_data_memory_with_stack DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [DATA_W-1:0] cells [0:DEPTH-1];
  logic [CELL_W-1:0] rec_cell;
  logic [KIND_W-1:0] rec_kind;

  op_item_t op_q[$];
  reply_t   reply_q[$];
  op_item_t drv_item;
  op_item_t seen_item;
  reply_t   want;
  reply_t   got;

  bit   took;
  bit   stuck;
  int   n_work;
  int   n_total;
  int   n_in;
  int   n_bad;
  int   quiet_cycles;
  logic calm;

  assign calm = (n_in >= 300) && (n_in < 480);

  always begin
    #4 clk = ~clk;
  end

  function automatic reply_t data_space_apply(op_item_t it);
    reply_t      r;
    logic [15:0] sp;
    r = '0;
    sp = {cells[SP_HI], cells[SP_LO]};
    case (it.operation)
      OP_READ: begin
        if (it.address > LAST_CELL) begin
          r.read_data = BYTE_FF;
        end else begin
          r.read_data = cells[it.address];
          rec_cell = it.address[CELL_W-1:0];
          rec_kind = KIND_SRC;
        end
      end
      OP_WRITE: begin
        if (it.address <= LAST_CELL) begin
          cells[it.address] = it.write_value;
          rec_cell = it.address[CELL_W-1:0];
          rec_kind = KIND_DEST;
        end
      end
      OP_PUSH: begin
        if (sp > STACK_FLOOR && sp <= LAST_CELL) begin
          cells[sp] = it.write_value;
          cells[SP_LO] = 8'((sp - 16'd1) & 16'h00FF);
          cells[SP_HI] = 8'((sp - 16'd1) >> 8);
          rec_cell = sp[CELL_W-1:0];
          rec_kind = KIND_DEST;
        end
      end
      OP_POP: begin
        if (sp >= LAST_CELL) begin
          r.read_data = BYTE_FF;
        end else begin
          sp = sp + 16'd1;
          r.read_data = cells[sp];
          cells[SP_LO] = sp[7:0];
          cells[SP_HI] = sp[15:8];
          rec_cell = sp[CELL_W-1:0];
          rec_kind = KIND_SRC;
        end
      end
      OP_TAKE: begin
        r.record_cell = rec_cell;
        r.record_kind = rec_kind;
        rec_cell = '0;
        rec_kind = KIND_NONE;
      end
      OP_CLEAR: begin
        foreach (cells[i]) cells[i] = '0;
        rec_cell = '0;
        rec_kind = KIND_NONE;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr = '0,
                                 logic [DATA_W-1:0] val = '0, bit hold = 1'b0);
    op_item_t it;
    it.operation   = op;
    it.address     = addr;
    it.write_value = val;
    it.drain       = hold;
    op_q.push_back(it);
    if (op <= OP_CLEAR) n_work++;
  endfunction

  function automatic void add_sp_set(logic [15:0] sp);
    add_op(OP_WRITE, 16'(SP_LO), sp[7:0]);
    add_op(OP_WRITE, 16'(SP_HI), sp[15:8]);
  endfunction

  function automatic logic [ADDR_W-1:0] near_cell(logic [15:0] sp);
    int a;
    a = int'(sp) + int'($urandom_range(0, 8)) - 4;
    if (a < 0 || a > LAST_CELL) a = $urandom_range(0, LAST_CELL);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [15:0] pick_sp();
    case ($urandom_range(0, 19))
      0: return 16'(STACK_FLOOR - 1);
      1: return 16'(STACK_FLOOR);
      2: return 16'(STACK_FLOOR + 1);
      3: return 16'(LAST_CELL - 1);
      4: return 16'(LAST_CELL);
      5: return 16'(DEPTH);
      6: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(STACK_FLOOR + 1, LAST_CELL - 1));
    endcase
  endfunction

  function automatic void add_stack_run();
    logic [15:0] sp;
    int          len;
    int          pick;
    sp = pick_sp();
    add_sp_set(sp);
    len = $urandom_range(4, 16);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_op(OP_PUSH, 16'($urandom), 8'($urandom));
      end else if (pick < 65) begin
        add_op(OP_POP, 16'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        add_op(OP_READ, $urandom_range(0, 1) ? near_cell(sp) : 16'($urandom_range(0, LAST_CELL)),
               8'($urandom));
      end else if (pick < 90) begin
        add_op(OP_WRITE, $urandom_range(0, 1) ? near_cell(sp) : 16'($urandom_range(0, LAST_CELL)),
               8'($urandom));
      end else begin
        add_op(OP_TAKE, 16'($urandom), 8'($urandom), $urandom_range(0, 49) == 0);
      end
    end
  endfunction

  function automatic void add_noise();
    logic [ADDR_W-1:0] a;
    a = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, LAST_CELL));
    add_op(3'($urandom_range(0, 7)), a, 8'($urandom), $urandom_range(0, 49) == 0);
  endfunction

  // hold each item until it transfers, then present the next or idle
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took) begin
      if (op_q.size() != 0 && (!op_q[0].drain || reply_q.size() == 0) &&
          (calm || $urandom_range(0, 99) >= 35)) begin
        drv_item = op_q.pop_front();
        in_ch.operation   <= drv_item.operation;
        in_ch.address     <= drv_item.address;
        in_ch.write_value <= drv_item.write_value;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
      quiet_cycles = 0;
    end else begin
      took <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got.read_data   = out_ch.read_data;
        got.record_cell = out_ch.record_cell;
        got.record_kind = out_ch.record_kind;
        if (reply_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 50) begin
            $display("%0t: unexpected transfer: rd=%02h cell=%03h kind=%0d", $time,
                     got.read_data, got.record_cell, got.record_kind);
          end
        end else begin
          want = reply_q.pop_front();
          if (got.read_data !== want.read_data || got.record_cell !== want.record_cell ||
              got.record_kind !== want.record_kind) begin
            n_bad++;
            if (n_bad <= 50) begin
              $display("%0t: mismatch: expected %02h/%03h/%0d, actual %02h/%03h/%0d",
                       $time, want.read_data, want.record_cell, want.record_kind,
                       got.read_data, got.record_cell, got.record_kind);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_item.operation   = in_ch.operation;
        seen_item.address     = in_ch.address;
        seen_item.write_value = in_ch.write_value;
        seen_item.drain       = 1'b0;
        reply_q.push_back(data_space_apply(seen_item));
        n_in++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else if (n_in < n_total || reply_q.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) stuck = 1'b1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_READ;
    in_ch.address = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    foreach (cells[i]) cells[i] = '0;
    rec_cell = '0;
    rec_kind = KIND_NONE;

    add_op(OP_READ, 16'd0);
    add_op(OP_READ, 16'(LAST_CELL));
    add_op(OP_READ, 16'(DEPTH));
    add_op(OP_READ, 16'hFFFF);
    add_op(OP_WRITE, 16'(LAST_CELL), 8'hFF);
    add_op(OP_WRITE, 16'hFFFF, 8'hA5);
    add_op(OP_TAKE);
    add_op(OP_TAKE);
    add_op(OP_POP);
    add_sp_set(16'(STACK_FLOOR));
    add_op(OP_PUSH, 16'd0, 8'h11);
    add_sp_set(16'(STACK_FLOOR + 1));
    add_op(OP_PUSH, 16'd0, 8'h80);
    add_op(OP_POP);
    add_sp_set(16'(LAST_CELL));
    add_op(OP_PUSH, 16'd0, 8'h7E);
    add_op(OP_POP);
    add_op(OP_POP);
    add_sp_set(16'(DEPTH));
    add_op(OP_PUSH, 16'd0, 8'h33);
    add_op(3'd6, 16'hFFFF, 8'hFF);
    add_op(3'd7, 16'h1234, 8'h56);
    add_op(OP_TAKE, 16'd0, 8'd0, 1'b1);
    add_op(OP_CLEAR);
    add_op(OP_READ, 16'(SP_LO));
    add_op(OP_TAKE);

    while (n_work < WORK_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  add_stack_run();
        [70:97]: add_noise();
        default: add_op(OP_CLEAR, 16'($urandom), 8'($urandom), $urandom_range(0, 1));
      endcase
    end
    n_total = op_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!stuck && !(n_in == n_total && reply_q.size() == 0)) @(negedge clk);
    if (!stuck) repeat (16) @(negedge clk);

    if (!stuck && n_bad == 0 && reply_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mdm_pkg.sv
rtl/core/mdm_ifs.sv
rtl/core/mdm_ctrl.sv
rtl/core/mdm_datapath.sv
rtl/core/mcu_data_memory_with_stack.sv
verif/tb_top.sv
